>>> rtl/core/triangle_pixel_coverage_test_defines.svh
// ----------------------------------------------------------------------------
// Triangle pixel coverage test - assertion macros
// Shared concurrent assertion wrappers for the coverage test RTL.
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_PIXEL_COVERAGE_TEST_DEFINES_SVH
`define TRIANGLE_PIXEL_COVERAGE_TEST_DEFINES_SVH

// Checked on every rising edge of clk_i outside reset
`define TPCT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked on every rising edge of clk_i, reset included
`define TPCT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

>>> rtl/core/tpct_pkg.sv
// ----------------------------------------------------------------------------
// Triangle pixel coverage test - package
// Field widths, register map codes, configuration struct and helpers.
// ----------------------------------------------------------------------------
package tpct_pkg;

  // Field widths
  localparam int PIX_W  = 12;
  localparam int DIM_W  = 13;
  localparam int VTX_W  = 21;

  // Parameter defaults
  localparam int MAX_DIM_DEF   = 4096;
  localparam int FRAC_BITS_DEF = 8;

  // Configuration port
  localparam int ADDR_W    = 5;
  localparam int DATA_W    = 32;
  localparam int DIM_RESET = 256;

  // Stream payload widths (padded to whole bytes)
  localparam int TDATA_IN_W  = 24;
  localparam int TDATA_OUT_W = 32;

  // Register index codes, word address paddr[4:2]
  typedef enum logic [2:0] {
    REG_IMAGE_WIDTH  = 3'd0,
    REG_IMAGE_HEIGHT = 3'd1,
    REG_VERTEX0_X    = 3'd2,
    REG_VERTEX0_Y    = 3'd3,
    REG_VERTEX1_X    = 3'd4,
    REG_VERTEX1_Y    = 3'd5,
    REG_VERTEX2_X    = 3'd6,
    REG_VERTEX2_Y    = 3'd7
  } tpct_reg_e;

  // Triangle and raster setup
  typedef struct packed {
    logic [DIM_W-1:0] image_width;
    logic [DIM_W-1:0] image_height;
    logic [VTX_W-1:0] vertex0_x;
    logic [VTX_W-1:0] vertex0_y;
    logic [VTX_W-1:0] vertex1_x;
    logic [VTX_W-1:0] vertex1_y;
    logic [VTX_W-1:0] vertex2_x;
    logic [VTX_W-1:0] vertex2_y;
  } tpct_cfg_t;

  // Larger of two elaboration-time integers
  function automatic int max_i(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

endpackage

>>> rtl/core/tpct_cfg.sv
// ----------------------------------------------------------------------------
// Triangle pixel coverage test - configuration registers
// APB-style register file holding the raster size and the three vertices.
// ----------------------------------------------------------------------------
module tpct_cfg (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [tpct_pkg::ADDR_W-1:0] paddr,
  input  logic [tpct_pkg::DATA_W-1:0] pwdata,
  output logic [tpct_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  output tpct_pkg::tpct_cfg_t        cfg_o
);

  tpct_pkg::tpct_cfg_t cfg_q;
  tpct_pkg::tpct_reg_e reg_sel;
  logic                wr_en;

  assign pready  = 1'b1;
  assign reg_sel = tpct_pkg::tpct_reg_e'(paddr[4:2]);
  assign wr_en   = psel && penable && pwrite && pready;

  // Register write, values truncated to the field width
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.image_width  <= tpct_pkg::DIM_W'(tpct_pkg::DIM_RESET);
      cfg_q.image_height <= tpct_pkg::DIM_W'(tpct_pkg::DIM_RESET);
      cfg_q.vertex0_x    <= '0;
      cfg_q.vertex0_y    <= '0;
      cfg_q.vertex1_x    <= '0;
      cfg_q.vertex1_y    <= '0;
      cfg_q.vertex2_x    <= '0;
      cfg_q.vertex2_y    <= '0;
    end else if (wr_en) begin
      unique case (reg_sel)
        tpct_pkg::REG_IMAGE_WIDTH:  cfg_q.image_width  <= pwdata[tpct_pkg::DIM_W-1:0];
        tpct_pkg::REG_IMAGE_HEIGHT: cfg_q.image_height <= pwdata[tpct_pkg::DIM_W-1:0];
        tpct_pkg::REG_VERTEX0_X:    cfg_q.vertex0_x    <= pwdata[tpct_pkg::VTX_W-1:0];
        tpct_pkg::REG_VERTEX0_Y:    cfg_q.vertex0_y    <= pwdata[tpct_pkg::VTX_W-1:0];
        tpct_pkg::REG_VERTEX1_X:    cfg_q.vertex1_x    <= pwdata[tpct_pkg::VTX_W-1:0];
        tpct_pkg::REG_VERTEX1_Y:    cfg_q.vertex1_y    <= pwdata[tpct_pkg::VTX_W-1:0];
        tpct_pkg::REG_VERTEX2_X:    cfg_q.vertex2_x    <= pwdata[tpct_pkg::VTX_W-1:0];
        tpct_pkg::REG_VERTEX2_Y:    cfg_q.vertex2_y    <= pwdata[tpct_pkg::VTX_W-1:0];
      endcase
    end
  end

  // Read mux
  always_comb begin
    unique case (reg_sel)
      tpct_pkg::REG_IMAGE_WIDTH:  prdata = tpct_pkg::DATA_W'(cfg_q.image_width);
      tpct_pkg::REG_IMAGE_HEIGHT: prdata = tpct_pkg::DATA_W'(cfg_q.image_height);
      tpct_pkg::REG_VERTEX0_X:    prdata = tpct_pkg::DATA_W'(cfg_q.vertex0_x);
      tpct_pkg::REG_VERTEX0_Y:    prdata = tpct_pkg::DATA_W'(cfg_q.vertex0_y);
      tpct_pkg::REG_VERTEX1_X:    prdata = tpct_pkg::DATA_W'(cfg_q.vertex1_x);
      tpct_pkg::REG_VERTEX1_Y:    prdata = tpct_pkg::DATA_W'(cfg_q.vertex1_y);
      tpct_pkg::REG_VERTEX2_X:    prdata = tpct_pkg::DATA_W'(cfg_q.vertex2_x);
      tpct_pkg::REG_VERTEX2_Y:    prdata = tpct_pkg::DATA_W'(cfg_q.vertex2_y);
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

>>> rtl/core/tpct_box.sv
// ----------------------------------------------------------------------------
// Triangle pixel coverage test - bounding box check
// Four-stage pipe: per-axis span tests, combine, then delay to align with
// the barycentric datapath.
// ----------------------------------------------------------------------------
module tpct_box #(
  parameter int MAX_DIM   = tpct_pkg::MAX_DIM_DEF,
  parameter int FRAC_BITS = tpct_pkg::FRAC_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  tpct_pkg::tpct_cfg_t        cfg_i,
  input  logic [tpct_pkg::PIX_W-1:0] col_i,
  input  logic [tpct_pkg::PIX_W-1:0] row_i,
  output logic                       ok_o
);

  // Integer part width and signed compare width
  localparam int IW = tpct_pkg::VTX_W - FRAC_BITS;
  localparam int BW = tpct_pkg::max_i(tpct_pkg::max_i(IW + 2, tpct_pkg::DIM_W + 2),
                                      $clog2(MAX_DIM + 1) + 2);

  // pos within [min, min(dim-1, max+1)], dim saturated to MAX_DIM
  function automatic logic span_ok(input logic [IW-1:0]             a,
                                   input logic [IW-1:0]             b,
                                   input logic [IW-1:0]             c,
                                   input logic [tpct_pkg::DIM_W-1:0] dim,
                                   input logic [tpct_pkg::PIX_W-1:0] pos);
    logic [IW-1:0]         lo;
    logic [IW-1:0]         hi;
    logic signed [BW-1:0]  d;
    logic signed [BW-1:0]  lim;
    logic signed [BW-1:0]  top;
    lo  = (a < b) ? a : b;
    lo  = (lo < c) ? lo : c;
    hi  = (a > b) ? a : b;
    hi  = (hi > c) ? hi : c;
    d   = (BW'(dim) > BW'(MAX_DIM)) ? BW'(MAX_DIM) : BW'(dim);
    lim = d - BW'(1);
    top = $signed(BW'(hi)) + BW'(1);
    if (top > lim) top = lim;
    return ($signed(BW'(pos)) >= $signed(BW'(lo))) && ($signed(BW'(pos)) <= top);
  endfunction

  logic col_ok_q, row_ok_q;
  logic ok_s2_q, ok_s3_q, ok_s4_q;

  // Stage 1: per-axis span, stages 2-4: combine and align
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      col_ok_q <= span_ok(cfg_i.vertex0_x[tpct_pkg::VTX_W-1:FRAC_BITS],
                          cfg_i.vertex1_x[tpct_pkg::VTX_W-1:FRAC_BITS],
                          cfg_i.vertex2_x[tpct_pkg::VTX_W-1:FRAC_BITS],
                          cfg_i.image_width, col_i);
      row_ok_q <= span_ok(cfg_i.vertex0_y[tpct_pkg::VTX_W-1:FRAC_BITS],
                          cfg_i.vertex1_y[tpct_pkg::VTX_W-1:FRAC_BITS],
                          cfg_i.vertex2_y[tpct_pkg::VTX_W-1:FRAC_BITS],
                          cfg_i.image_height, row_i);
      ok_s2_q  <= col_ok_q && row_ok_q;
      ok_s3_q  <= ok_s2_q;
      ok_s4_q  <= ok_s3_q;
    end
  end

  assign ok_o = ok_s4_q;

endmodule

>>> rtl/core/tpct_bary.sv
// ----------------------------------------------------------------------------
// Triangle pixel coverage test - barycentric inside test
// Four-stage datapath: differences, products, numerator sums, sign decision.
// ----------------------------------------------------------------------------
module tpct_bary #(
  parameter int FRAC_BITS = tpct_pkg::FRAC_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  tpct_pkg::tpct_cfg_t        cfg_i,
  input  logic [tpct_pkg::PIX_W-1:0] col_i,
  input  logic [tpct_pkg::PIX_W-1:0] row_i,
  output logic                       inside_o
);

  localparam int PXW = tpct_pkg::PIX_W + FRAC_BITS;               // pixel center
  localparam int DW  = tpct_pkg::max_i(PXW, tpct_pkg::VTX_W) + 1; // signed difference
  localparam int PW  = 2 * DW;                                    // product
  localparam int SW  = PW + 1;                                    // two-term sum
  localparam int GW  = PW + 3;                                    // gamma numerator
  localparam logic [PXW-1:0] HALF = PXW'(1) << (FRAC_BITS - 1);

  logic [PXW-1:0] px, py;

  // Stage 1 registers: edge terms and center offsets from vertex 2
  logic signed [DW-1:0] bcy_q, cbx_q, cay_q, acx_q, aacy_q, dx_q, dy_q;
  // Stage 2 registers: products
  logic signed [PW-1:0] den0_q, den1_q, na0_q, na1_q, nb0_q, nb1_q;
  // Stage 3 registers: numerators and denominator
  logic signed [SW-1:0] den_q, na_q, nb_q;
  // Stage 4 decision
  logic signed [GW-1:0] ng;
  logic                 inside_d, inside_q;

  // Pixel center in vertex fixed point
  assign px = (PXW'(col_i) << FRAC_BITS) | HALF;
  assign py = (PXW'(row_i) << FRAC_BITS) | HALF;

  // Stage 1: differences
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      bcy_q  <= $signed(DW'(cfg_i.vertex1_y)) - $signed(DW'(cfg_i.vertex2_y));
      cbx_q  <= $signed(DW'(cfg_i.vertex2_x)) - $signed(DW'(cfg_i.vertex1_x));
      cay_q  <= $signed(DW'(cfg_i.vertex2_y)) - $signed(DW'(cfg_i.vertex0_y));
      acx_q  <= $signed(DW'(cfg_i.vertex0_x)) - $signed(DW'(cfg_i.vertex2_x));
      aacy_q <= $signed(DW'(cfg_i.vertex0_y)) - $signed(DW'(cfg_i.vertex2_y));
      dx_q   <= $signed(DW'(px)) - $signed(DW'(cfg_i.vertex2_x));
      dy_q   <= $signed(DW'(py)) - $signed(DW'(cfg_i.vertex2_y));
    end
  end

  // Stage 2: six products
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      den0_q <= bcy_q * acx_q;
      den1_q <= cbx_q * aacy_q;
      na0_q  <= bcy_q * dx_q;
      na1_q  <= cbx_q * dy_q;
      nb0_q  <= cay_q * dx_q;
      nb1_q  <= acx_q * dy_q;
    end
  end

  // Stage 3: sums
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      den_q <= SW'(den0_q) + SW'(den1_q);
      na_q  <= SW'(na0_q) + SW'(na1_q);
      nb_q  <= SW'(nb0_q) + SW'(nb1_q);
    end
  end

  // Stage 4: gamma and sign test; a zero denominator is never inside, a negative one flips every test
  always_comb begin
    ng = GW'(den_q) - GW'(na_q) - GW'(nb_q);
    priority if (den_q == '0) begin
      inside_d = 1'b0;
    end else if (den_q < 0) begin
      inside_d = (na_q <= 0) && (nb_q <= 0) && (ng <= 0);
    end else begin
      inside_d = (na_q >= 0) && (nb_q >= 0) && (ng >= 0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      inside_q <= inside_d;
    end
  end

  assign inside_o = inside_q;

endmodule

>>> rtl/core/triangle_pixel_coverage_test.sv
// ----------------------------------------------------------------------------
// Triangle pixel coverage test - top level
// Tests each streamed pixel center against one configured triangle.
//
//   Channel   Direction  Payload (low bit first)
//   s_axis    in         pixel_col[11:0], pixel_row[23:12]
//   m_axis    out        covered[0], out_col[12:1], out_row[24:13]
//   apb       in/out     8 registers at 4*i: width, height, v0..v2 x/y
//
// One item per clock while m_axis is not stalled, through the four-stage pipe
// (differences, multipliers, sums, sign decision).
// Reset clears the stage valid bits and loads the register reset values.
// A stalled m_axis freezes every stage at once; s_axis_tready drops with it.
// ----------------------------------------------------------------------------
`include "triangle_pixel_coverage_test_defines.svh"

module triangle_pixel_coverage_test #(
  parameter int MAX_DIM   = tpct_pkg::MAX_DIM_DEF,
  parameter int FRAC_BITS = tpct_pkg::FRAC_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Configuration port
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [tpct_pkg::ADDR_W-1:0]      paddr,
  input  logic [tpct_pkg::DATA_W-1:0]      pwdata,
  output logic [tpct_pkg::DATA_W-1:0]      prdata,
  output logic                             pready,
  // Pixel items in
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [tpct_pkg::TDATA_IN_W-1:0]  s_axis_tdata,  // pixel_col, pixel_row
  // Coverage items out
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [tpct_pkg::TDATA_OUT_W-1:0] m_axis_tdata   // covered, out_col, out_row, pad
);

  localparam int PIPE_DEPTH = 4;
  localparam int PAD_W = tpct_pkg::TDATA_OUT_W - 2 * tpct_pkg::PIX_W - 1;

  tpct_pkg::tpct_cfg_t        cfg;
  logic                       en;
  logic                       box_ok, tri_hit;
  logic [tpct_pkg::PIX_W-1:0] in_col, in_row;
  logic [PIPE_DEPTH-1:0]      valid_q;
  logic [tpct_pkg::PIX_W-1:0] col_q [PIPE_DEPTH];
  logic [tpct_pkg::PIX_W-1:0] row_q [PIPE_DEPTH];

  assign in_col = s_axis_tdata[tpct_pkg::PIX_W-1:0];
  assign in_row = s_axis_tdata[2*tpct_pkg::PIX_W-1:tpct_pkg::PIX_W];

  // Whole pipe advances unless the last stage holds an item not taken
  assign en            = !valid_q[PIPE_DEPTH-1] || m_axis_tready;
  assign s_axis_tready = en;

  tpct_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  tpct_box #(
    .MAX_DIM   (MAX_DIM),
    .FRAC_BITS (FRAC_BITS)
  ) u_box (
    .clk_i (clk_i),
    .en_i  (en),
    .cfg_i (cfg),
    .col_i (in_col),
    .row_i (in_row),
    .ok_o  (box_ok)
  );

  tpct_bary #(
    .FRAC_BITS (FRAC_BITS)
  ) u_bary (
    .clk_i    (clk_i),
    .en_i     (en),
    .cfg_i    (cfg),
    .col_i    (in_col),
    .row_i    (in_row),
    .inside_o (tri_hit)
  );

  // Stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en) begin
      valid_q <= {valid_q[PIPE_DEPTH-2:0], s_axis_tvalid};
    end
  end

  // Pixel echo travels alongside the datapath
  always_ff @(posedge clk_i) begin
    if (en) begin
      col_q[0] <= in_col;
      row_q[0] <= in_row;
      for (int i = 1; i < PIPE_DEPTH; i++) begin
        col_q[i] <= col_q[i-1];
        row_q[i] <= row_q[i-1];
      end
    end
  end

  assign m_axis_tvalid = valid_q[PIPE_DEPTH-1];
  assign m_axis_tdata  = {PAD_W'(0), row_q[PIPE_DEPTH-1], col_q[PIPE_DEPTH-1],
                          box_ok & tri_hit};

  // Checks
  `TPCT_ASSERT(a_accept_enters, s_axis_tvalid && s_axis_tready |=> valid_q[0],
               "accepted item did not enter stage one")
  `TPCT_ASSERT(a_stall_holds, !en |=> $stable(valid_q) && $stable(m_axis_tdata),
               "pipeline moved during a stall")
  `TPCT_ASSERT(a_item_reaches_out, en && valid_q[PIPE_DEPTH-2] |=> m_axis_tvalid,
               "item lost before the output stage")
  `TPCT_ASSERT_ALWAYS(a_reset_empty, !rst_ni |=> valid_q == '0,
                      "pipeline not empty in reset")

endmodule
